// ----- sv/cvdc_pkg.sv -----
// Shared types and constants for the 3x3 convolution filter with divide and clamp.
package cvdc_pkg;

    localparam int PIX_W         = 8;
    localparam int POS_W         = 10;
    localparam int HGT_W         = 11;
    localparam int MAX_HEIGHT    = 1024;
    localparam int PIX_MAX       = 255;
    localparam int SUM_W         = 16;
    localparam int DIV_W         = 15;
    localparam int DVS_W         = 8;
    localparam int TAPS          = 3;
    localparam int CFG_DATA_W    = 63;
    localparam int CFG_INDEX_W   = 2;
    localparam int OUT_TDATA_W   = 32;
    localparam int MAX_WIDTH_DEF = 1024;
    localparam int COEF_BITS_DEF = 7;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_COEF    = 2'd0,
        REG_DIVISOR = 2'd1,
        REG_WIDTH   = 2'd2,
        REG_HEIGHT  = 2'd3
    } cfg_reg_t;

    // one window column, index 0 is the oldest row
    typedef logic [TAPS-1:0][PIX_W-1:0] win_col_t;

    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             last;
    } side_t;

    typedef struct packed {
        logic             valid;
        logic             neg;
        logic [DVS_W-1:0] rem;
        logic [DIV_W-1:0] num;
        logic [DIV_W-1:0] quo;
        side_t            side;
    } div_lane_t;

endpackage

// ----- sv/cvdc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module cvdc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- sv/cvdc_win_cell.sv -----
// Window column cell: holds one column of the 3x3 window and its partial sum.
module cvdc_win_cell #(
    parameter int COEF_BITS = cvdc_pkg::COEF_BITS_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    shift,
    input  logic                                    advance,
    input  cvdc_pkg::win_col_t                      col_in,
    input  logic [cvdc_pkg::TAPS*COEF_BITS-1:0]     coefs,
    output cvdc_pkg::win_col_t                      col_out,
    output logic signed [COEF_BITS+10:0]            psum
);

    localparam int PSW = COEF_BITS + 11;

    cvdc_pkg::win_col_t       col_reg;
    logic signed [PSW-1:0]    psum_reg;
    logic signed [PSW-1:0]    psum_next;
    logic signed [COEF_BITS-1:0] coef_s [cvdc_pkg::TAPS];

    always_comb
    begin
        for (int i = 0; i < cvdc_pkg::TAPS; i++)
        begin
            coef_s[i] = $signed(coefs[i*COEF_BITS +: COEF_BITS]);
        end
    end

    always_comb
    begin
        psum_next = '0;
        for (int i = 0; i < cvdc_pkg::TAPS; i++)
        begin
            psum_next = psum_next
                + PSW'($signed({1'b0, col_reg[i]})) * PSW'(coef_s[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
        end
        else if (shift)
        begin
            col_reg <= col_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            psum_reg <= psum_next;
        end
    end

    assign col_out = col_reg;
    assign psum    = psum_reg;

endmodule

// ----- sv/cvdc_div_cell.sv -----
// Divider cell: resolves one quotient bit per stage, restoring form.
module cvdc_div_cell (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              advance,
    input  logic [cvdc_pkg::DVS_W-1:0]        divisor,
    input  cvdc_pkg::div_lane_t               lane_in,
    output cvdc_pkg::div_lane_t               lane_out
);

    cvdc_pkg::div_lane_t          lane_reg;
    cvdc_pkg::div_lane_t          lane_next;
    logic [cvdc_pkg::DVS_W:0]     rem_sh;
    logic [cvdc_pkg::DVS_W:0]     rem_sub;
    logic                         ge;

    always_comb
    begin
        rem_sh    = {lane_in.rem, lane_in.num[cvdc_pkg::DIV_W-1]};
        ge        = rem_sh >= {1'b0, divisor};
        rem_sub   = rem_sh - {1'b0, divisor};
        lane_next = lane_in;
        lane_next.rem = ge ? rem_sub[cvdc_pkg::DVS_W-1:0] : rem_sh[cvdc_pkg::DVS_W-1:0];
        lane_next.num = {lane_in.num[cvdc_pkg::DIV_W-2:0], 1'b0};
        lane_next.quo = {lane_in.quo[cvdc_pkg::DIV_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane_reg <= '0;
        end
        else if (advance)
        begin
            lane_reg <= lane_next;
        end
    end

    assign lane_out = lane_reg;

endmodule

// ----- sv/conv3x3_divide_clamp.sv -----
// 3x3 convolution filter over raster pixels with divide by a divisor and clamp to 0..255.
// Stages: input register, window cells, sum register, 15-cell divider chain, output register.
// Throughput: one pixel per cycle unless m_axis stalls; all stages advance together.
// Border pixels give no result; every pixel still moves the window and the line stores.
// Reset: registers take their defaults, window clears, then a pass over all MAX_WIDTH addresses
// (1024 by default) zeroes both line stores with s_axis_tready held low.
module conv3x3_divide_clamp #(
    parameter int MAX_WIDTH = cvdc_pkg::MAX_WIDTH_DEF,
    parameter int COEF_BITS = cvdc_pkg::COEF_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [cvdc_pkg::PIX_W-1:0]          s_axis_tdata,  // [7:0] pixel_value
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [7:0] filtered_value, [17:8] out_row, [27:18] out_col, [31:28] zero
    output logic [cvdc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    output logic                                m_axis_tlast,  // frame_last
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [cvdc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [cvdc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int WEW = ($clog2(MAX_WIDTH + 1) > 11) ? $clog2(MAX_WIDTH + 1) : 11;
    localparam int PSW = COEF_BITS + 11;
    localparam int SW  = (PSW + 2 > cvdc_pkg::SUM_W) ? PSW + 2 : cvdc_pkg::SUM_W;
    localparam int PW  = cvdc_pkg::PIX_W;
    localparam int HW  = cvdc_pkg::HGT_W;
    localparam int DW  = cvdc_pkg::DIV_W;

    // configuration
    logic [cvdc_pkg::CFG_DATA_W-1:0] coef_reg;
    logic [cvdc_pkg::DVS_W-1:0]      divisor_reg;
    logic [HW-1:0]                   width_reg;
    logic [HW-1:0]                   height_reg;

    // line store clearing pass
    logic          clear_reg;
    logic [CW-1:0] clr_addr_reg;

    // raster position
    logic [cvdc_pkg::POS_W-1:0] row_reg;
    logic [cvdc_pkg::POS_W-1:0] row_next;
    logic [CW-1:0]              col_reg;
    logic [CW-1:0]              col_next;

    // pipeline
    logic                    v1_reg;
    logic                    emit1_reg;
    logic [PW-1:0]           pix1_reg;
    logic [CW-1:0]           c1_reg;
    cvdc_pkg::side_t         side1_reg;
    logic                    v2_reg;
    cvdc_pkg::side_t         side2_reg;
    logic                    v3_reg;
    cvdc_pkg::side_t         side3_reg;
    logic                    v4_reg;
    logic [cvdc_pkg::SUM_W-1:0] sum4_reg;
    logic [cvdc_pkg::SUM_W-1:0] sum4_next;
    cvdc_pkg::side_t         side4_reg;
    logic                    out_valid_reg;
    logic [PW-1:0]           out_value_reg;
    logic [PW-1:0]           out_value_next;
    cvdc_pkg::side_t         out_side_reg;

    logic            en;
    logic            accept;
    logic [WEW-1:0]  w_eff;
    logic [WEW-1:0]  width_ext;
    logic [HW-1:0]   h_eff;
    logic [WEW-1:0]  c_ext;
    logic [WEW-1:0]  c_inc;
    logic [WEW-1:0]  c_dec;
    logic [HW-1:0]   r_ext;
    logic [HW-1:0]   r_inc;
    logic            in_frame;
    logic            emit0;
    cvdc_pkg::side_t side0;

    logic [PW-1:0]              up_rd;
    logic [PW-1:0]              mid_rd;
    logic                       wr_en;
    logic [CW-1:0]              wr_addr;
    logic [PW-1:0]              up_wr;
    logic [PW-1:0]              mid_wr;
    cvdc_pkg::win_col_t         new_col;
    cvdc_pkg::win_col_t         link1;
    cvdc_pkg::win_col_t         link0;
    logic [cvdc_pkg::TAPS*COEF_BITS-1:0] cell_coef [cvdc_pkg::TAPS];
    logic signed [PSW-1:0]      psum [cvdc_pkg::TAPS];
    logic [SW-1:0]              sum_full;
    logic [cvdc_pkg::DVS_W-1:0] dvs_eff;
    cvdc_pkg::div_lane_t        lane [DW+1];

    assign cfg_ready = 1'b1;
    assign en        = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = en && !clear_reg;
    assign accept    = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg    <= '0;
            divisor_reg <= cvdc_pkg::DVS_W'(1);
            width_reg   <= HW'(1024);
            height_reg  <= HW'(1024);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cvdc_pkg::cfg_reg_t'(cfg_index))
                cvdc_pkg::REG_COEF:    coef_reg    <= cfg_data;
                cvdc_pkg::REG_DIVISOR: divisor_reg <= cfg_data[cvdc_pkg::DVS_W-1:0];
                cvdc_pkg::REG_WIDTH:   width_reg   <= cfg_data[HW-1:0];
                cvdc_pkg::REG_HEIGHT:  height_reg  <= cfg_data[HW-1:0];
            endcase
        end
    end

    // effective sizes and position decode
    always_comb
    begin
        width_ext = WEW'(width_reg);
        if (width_ext < WEW'(3))
        begin
            w_eff = WEW'(3);
        end
        else if (width_ext > WEW'(MAX_WIDTH))
        begin
            w_eff = WEW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = width_ext;
        end

        if (height_reg < HW'(3))
        begin
            h_eff = HW'(3);
        end
        else if (height_reg > HW'(cvdc_pkg::MAX_HEIGHT))
        begin
            h_eff = HW'(cvdc_pkg::MAX_HEIGHT);
        end
        else
        begin
            h_eff = height_reg;
        end

        c_ext  = WEW'(col_reg);
        c_inc  = c_ext + WEW'(1);
        c_dec  = c_ext - WEW'(1);
        r_ext  = HW'(row_reg);
        r_inc  = r_ext + HW'(1);
        in_frame = (r_ext < h_eff) && (c_ext < w_eff);
        emit0  = in_frame && (r_ext >= HW'(2)) && (c_ext >= WEW'(2));
        side0.row  = row_reg - cvdc_pkg::POS_W'(1);
        side0.col  = c_dec[cvdc_pkg::POS_W-1:0];
        side0.last = (r_ext == h_eff - HW'(1)) && (c_ext == w_eff - WEW'(1));

        if (c_inc >= w_eff)
        begin
            col_next = '0;
            row_next = (r_inc >= h_eff) ? '0 : r_inc[cvdc_pkg::POS_W-1:0];
        end
        else
        begin
            col_next = c_inc[CW-1:0];
            row_next = row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_reg     <= 1'b1;
            clr_addr_reg  <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            v1_reg        <= 1'b0;
            emit1_reg     <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (clear_reg)
            begin
                clr_addr_reg <= clr_addr_reg + CW'(1);
                if (clr_addr_reg == CW'(MAX_WIDTH - 1))
                begin
                    clear_reg <= 1'b0;
                end
            end
            if (accept)
            begin
                row_reg <= row_next;
                col_reg <= col_next;
            end
            if (en)
            begin
                v1_reg        <= accept;
                emit1_reg     <= accept && emit0;
                v2_reg        <= v1_reg && emit1_reg;
                v3_reg        <= v2_reg;
                v4_reg        <= v3_reg;
                out_valid_reg <= lane[DW].valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pix1_reg     <= s_axis_tdata;
            c1_reg       <= col_reg;
            side1_reg    <= side0;
            side2_reg    <= side1_reg;
            side3_reg    <= side2_reg;
            side4_reg    <= side3_reg;
            sum4_reg     <= sum4_next;
            out_value_reg <= out_value_next;
            out_side_reg <= lane[DW].side;
        end
    end

    // line stores: read at the incoming column, write back one stage later
    assign wr_en   = clear_reg || (en && v1_reg);
    assign wr_addr = clear_reg ? clr_addr_reg : c1_reg;
    assign up_wr   = clear_reg ? '0 : mid_rd;
    assign mid_wr  = clear_reg ? '0 : pix1_reg;

    cvdc_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_WIDTH)
    ) u_ram_upper (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (up_wr),
        .rd_en   (en),
        .rd_addr (col_reg),
        .rd_data (up_rd)
    );

    cvdc_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_WIDTH)
    ) u_ram_middle (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (mid_wr),
        .rd_en   (en),
        .rd_addr (col_reg),
        .rd_data (mid_rd)
    );

    // window: three column cells, newest column enters cell 2
    always_comb
    begin
        new_col[0] = up_rd;
        new_col[1] = mid_rd;
        new_col[2] = pix1_reg;
        for (int j = 0; j < cvdc_pkg::TAPS; j++)
        begin
            for (int i = 0; i < cvdc_pkg::TAPS; i++)
            begin
                cell_coef[j][i*COEF_BITS +: COEF_BITS] =
                    coef_reg[(i*cvdc_pkg::TAPS + j)*COEF_BITS +: COEF_BITS];
            end
        end
    end

    cvdc_win_cell #(
        .COEF_BITS (COEF_BITS)
    ) u_win_cell2 (
        .clk     (clk),
        .rst_n   (rst_n),
        .shift   (en && v1_reg),
        .advance (en),
        .col_in  (new_col),
        .coefs   (cell_coef[2]),
        .col_out (link1),
        .psum    (psum[2])
    );

    cvdc_win_cell #(
        .COEF_BITS (COEF_BITS)
    ) u_win_cell1 (
        .clk     (clk),
        .rst_n   (rst_n),
        .shift   (en && v1_reg),
        .advance (en),
        .col_in  (link1),
        .coefs   (cell_coef[1]),
        .col_out (link0),
        .psum    (psum[1])
    );

    cvdc_win_cell #(
        .COEF_BITS (COEF_BITS)
    ) u_win_cell0 (
        .clk     (clk),
        .rst_n   (rst_n),
        .shift   (en && v1_reg),
        .advance (en),
        .col_in  (link0),
        .coefs   (cell_coef[0]),
        .col_out (),
        .psum    (psum[0])
    );

    // wrap the window sum to 16 bits
    always_comb
    begin
        sum_full  = SW'(psum[0]) + SW'(psum[1]) + SW'(psum[2]);
        sum4_next = sum_full[cvdc_pkg::SUM_W-1:0];
    end

    // divider chain on the magnitude of a non-negative sum
    assign dvs_eff = (divisor_reg == '0) ? cvdc_pkg::DVS_W'(1) : divisor_reg;

    always_comb
    begin
        lane[0].valid = v4_reg;
        lane[0].neg   = sum4_reg[cvdc_pkg::SUM_W-1];
        lane[0].rem   = '0;
        lane[0].num   = sum4_reg[DW-1:0];
        lane[0].quo   = '0;
        lane[0].side  = side4_reg;
    end

    for (genvar g = 0; g < DW; g++)
    begin : g_div
        cvdc_div_cell u_div_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (en),
            .divisor  (dvs_eff),
            .lane_in  (lane[g]),
            .lane_out (lane[g+1])
        );
    end

    // clamp to the pixel range
    always_comb
    begin
        if (lane[DW].neg)
        begin
            out_value_next = '0;
        end
        else if (lane[DW].quo > DW'(cvdc_pkg::PIX_MAX))
        begin
            out_value_next = PW'(cvdc_pkg::PIX_MAX);
        end
        else
        begin
            out_value_next = lane[DW].quo[PW-1:0];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_side_reg.last;
    assign m_axis_tdata  = {
        {(cvdc_pkg::OUT_TDATA_W - PW - 2*cvdc_pkg::POS_W){1'b0}},
        out_side_reg.col,
        out_side_reg.row,
        out_value_reg
    };

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the 3x3 convolution filter: directed frames, random frames, scoreboard.
module tb_top;

    localparam int LATENCY       = 19;
    localparam int SETTLE        = LATENCY + 16;
    localparam int RANDOM_PIXELS = 240;
    localparam int REPORT_MAX    = 10;

    localparam logic [3:0] M_C = 4'b0001;
    localparam logic [3:0] M_D = 4'b0010;
    localparam logic [3:0] M_W = 4'b0100;
    localparam logic [3:0] M_H = 4'b1000;

    localparam logic [62:0] K_ZERO    = '0;
    localparam logic [62:0] K_IDENT   = {28'd0, 7'd1, 28'd0};
    localparam logic [62:0] K_BOX     = {9{7'd1}};
    localparam logic [62:0] K_MAXPOS  = {9{7'h3F}};
    localparam logic [62:0] K_MAXNEG  = {9{7'h40}};
    localparam logic [62:0] K_ALLONES = {63{1'b1}};
    localparam logic [62:0] K_LAPLACE = {7'h7F, 7'h7F, 7'h7F, 7'h7F, 7'd8,
                                         7'h7F, 7'h7F, 7'h7F, 7'h7F};
    localparam logic [62:0] K_SOBEL   = {7'd1, 7'd0, 7'h7F, 7'd2, 7'd0,
                                         7'h7E, 7'd1, 7'd0, 7'h7F};

    typedef enum int {PIX_CONST, PIX_RAMP, PIX_RANDOM, PIX_EXTREME, PIX_LOW} pix_mode_t;

    typedef struct packed {
        logic [7:0] value;
        logic [9:0] row;
        logic [9:0] col;
        logic       last;
    } filtered_t;

    typedef struct packed {
        logic [3:0]  mask;
        logic [62:0] coef;
        logic [7:0]  divisor;
        logic [10:0] width;
        logic [10:0] height;
        pix_mode_t   mode;
        logic [7:0]  level;
        int          count;
        int          fixed;
    } frame_row_t;

    // count -1: run to the end of the frame; fixed -1: value from the filter model
    localparam frame_row_t PLAN [20] = '{
        '{M_W | M_H,             K_ZERO,    8'd0,   11'd3,    11'd3,    PIX_CONST,   8'd255, -1,  0},
        '{M_C,                   K_IDENT,   8'd0,   11'd0,    11'd0,    PIX_CONST,   8'd200, -1, 200},
        '{M_C | M_D | M_W | M_H, K_BOX,     8'd9,   11'd5,    11'd4,    PIX_CONST,   8'd90,  -1, 90},
        '{M_C | M_D,             K_MAXPOS,  8'd1,   11'd0,    11'd0,    PIX_CONST,   8'd1,   -1, 255},
        '{M_C,                   K_MAXNEG,  8'd0,   11'd0,    11'd0,    PIX_CONST,   8'd1,   -1,  0},
        '{M_C,                   K_MAXPOS,  8'd0,   11'd0,    11'd0,    PIX_CONST,   8'd255, -1, -1},
        '{M_C,                   K_MAXNEG,  8'd0,   11'd0,    11'd0,    PIX_RANDOM,  8'd0,   -1, -1},
        '{M_C | M_D,             K_IDENT,   8'd0,   11'd0,    11'd0,    PIX_CONST,   8'd77,  -1, 77},
        '{M_D,                   K_ZERO,    8'd255, 11'd0,    11'd0,    PIX_CONST,   8'd254, -1,  0},
        '{M_D,                   K_ZERO,    8'd255, 11'd0,    11'd0,    PIX_CONST,   8'd255, -1,  1},
        '{M_C | M_D | M_W | M_H, K_LAPLACE, 8'd1,   11'd9,    11'd7,    PIX_RANDOM,  8'd0,   -1, -1},
        '{M_C | M_W | M_H,       K_ALLONES, 8'd0,   11'd0,    11'd1,    PIX_RAMP,    8'd0,   -1, -1},
        '{M_W | M_H,             K_ZERO,    8'd0,   11'd2,    11'd2,    PIX_EXTREME, 8'd0,   -1, -1},
        '{M_C | M_D | M_W | M_H, K_SOBEL,   8'd4,   11'd8,    11'd6,    PIX_RANDOM,  8'd0,   30, -1},
        '{M_W,                   K_ZERO,    8'd0,   11'd4,    11'd0,    PIX_RAMP,    8'd9,   -1, -1},
        '{M_W | M_H,             K_ZERO,    8'd0,   11'd8,    11'd8,    PIX_RANDOM,  8'd0,   50, -1},
        '{M_H,                   K_ZERO,    8'd0,   11'd0,    11'd4,    PIX_RANDOM,  8'd0,   -1, -1},
        '{M_C | M_D | M_W | M_H, K_BOX,     8'd9,   11'd1024, 11'd3,    PIX_RANDOM,  8'd0,   40, -1},
        '{M_W | M_H,             K_ZERO,    8'd0,   11'd3,    11'd1024, PIX_RANDOM,  8'd0,   40, -1},
        '{M_W | M_H,             K_ZERO,    8'd0,   11'd2047, 11'd2047, PIX_LOW,     8'd0,   40, -1}
    };

    logic                                 clk = 1'b0;
    logic                                 rst_n = 1'b0;
    logic                                 s_axis_tvalid = 1'b0;
    logic                                 s_axis_tready;
    logic [cvdc_pkg::PIX_W-1:0]           s_axis_tdata = '0;
    logic                                 m_axis_tvalid;
    logic                                 m_axis_tready = 1'b0;
    logic [cvdc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata;
    logic                                 m_axis_tlast;
    logic                                 cfg_valid = 1'b0;
    logic                                 cfg_ready;
    cvdc_pkg::cfg_reg_t                   cfg_index = cvdc_pkg::REG_COEF;
    logic [cvdc_pkg::CFG_DATA_W-1:0]      cfg_data = '0;

    logic [62:0] coef_reg = '0;
    logic [7:0]  divisor_reg = 8'd1;
    logic [10:0] width_reg = 11'd1024;
    logic [10:0] height_reg = 11'd1024;
    logic [7:0]  upper_line [cvdc_pkg::MAX_WIDTH_DEF];
    logic [7:0]  middle_line [cvdc_pkg::MAX_WIDTH_DEF];
    logic [7:0]  window [9];
    int unsigned row_pos = 0;
    int unsigned col_pos = 0;

    filtered_t expected_filtered [$];
    int errors = 0;
    int pixels_sent = 0;
    int src_idle = 0;
    int sink_idle = 0;

    conv3x3_divide_clamp u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic int unsigned eff_cols();
        if (width_reg < 3) return 3;
        if (width_reg > cvdc_pkg::MAX_WIDTH_DEF) return cvdc_pkg::MAX_WIDTH_DEF;
        return 32'(width_reg);
    endfunction

    function automatic int unsigned eff_rows();
        if (height_reg < 3) return 3;
        if (height_reg > cvdc_pkg::MAX_HEIGHT) return cvdc_pkg::MAX_HEIGHT;
        return 32'(height_reg);
    endfunction

    task automatic filter_pixel(input logic [7:0] pix, input int fixed);
        int unsigned w, h, r, c, ci;
        int acc, sum, quo, dvs, tap;
        logic [15:0] low16;
        filtered_t res;
        w = eff_cols();
        h = eff_rows();
        r = row_pos;
        c = col_pos;
        ci = c % cvdc_pkg::MAX_WIDTH_DEF;
        for (int k = 0; k < 3; k++)
        begin
            window[k*3]   = window[k*3+1];
            window[k*3+1] = window[k*3+2];
        end
        window[2] = upper_line[ci];
        window[5] = middle_line[ci];
        window[8] = pix;
        upper_line[ci] = window[5];
        middle_line[ci] = pix;
        if (r < h && c < w && r >= 2 && c >= 2)
        begin
            acc = 0;
            for (int k = 0; k < 9; k++)
            begin
                tap = int'($signed(coef_reg[k*cvdc_pkg::COEF_BITS_DEF +:
                                            cvdc_pkg::COEF_BITS_DEF]));
                acc += int'(window[k]) * tap;
            end
            low16 = acc[15:0];
            sum = int'($signed(low16));
            dvs = (divisor_reg == 0) ? 1 : int'(divisor_reg);
            quo = sum / dvs;
            if (quo < 0) quo = 0;
            if (quo > cvdc_pkg::PIX_MAX) quo = cvdc_pkg::PIX_MAX;
            res.value = quo[7:0];
            res.row = 10'(r - 1);
            res.col = 10'(c - 1);
            res.last = (r == h - 1 && c == w - 1);
            if (fixed >= 0) res.value = 8'(fixed);
            expected_filtered.push_back(res);
        end
        if (c + 1 >= w)
        begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
        end
        else
        begin
            col_pos = c + 1;
        end
    endtask

    task automatic send_pixel(input logic [7:0] pix, input int fixed);
        while ($urandom_range(0, 99) < src_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= pix;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        filter_pixel(pix, fixed);
        pixels_sent++;
    endtask

    function automatic logic [7:0] next_pixel(input pix_mode_t mode, input logic [7:0] level,
                                              input int idx);
        case (mode)
            PIX_CONST:   return level;
            PIX_RAMP:    return 8'(idx * 37 + level);
            PIX_EXTREME: return $urandom_range(0, 1) ? 8'd255 : 8'd0;
            PIX_LOW:     return 8'($urandom_range(0, 15));
            default:     return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_frame(input pix_mode_t mode, input logic [7:0] level, input int count,
                              input int fixed);
        int n;
        n = 0;
        while ((count < 0) ? (n == 0 || row_pos != 0 || col_pos != 0) : (n < count))
        begin
            send_pixel(next_pixel(mode, level, n), fixed);
            n++;
        end
    endtask

    // hold off the stream until the pipeline is empty
    task automatic quiesce();
        s_axis_tvalid <= 1'b0;
        while (expected_filtered.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_regs(input logic [3:0] mask, input logic [62:0] coef,
                              input logic [7:0] dvs, input logic [10:0] w, input logic [10:0] h);
        logic [cvdc_pkg::CFG_DATA_W-1:0] value;
        cvdc_pkg::cfg_reg_t idx;
        for (int i = 0; i < 4; i++)
        begin
            if (mask[i])
            begin
                idx = cvdc_pkg::cfg_reg_t'(i);
                case (idx)
                    cvdc_pkg::REG_COEF:    value = coef;
                    cvdc_pkg::REG_DIVISOR: value = cvdc_pkg::CFG_DATA_W'(dvs);
                    cvdc_pkg::REG_WIDTH:   value = cvdc_pkg::CFG_DATA_W'(w);
                    default:               value = cvdc_pkg::CFG_DATA_W'(h);
                endcase
                cfg_valid <= 1'b1;
                cfg_index <= idx;
                cfg_data <= value;
                @(posedge clk);
                while (!cfg_ready) @(posedge clk);
                case (idx)
                    cvdc_pkg::REG_COEF:    coef_reg = value;
                    cvdc_pkg::REG_DIVISOR: divisor_reg = value[7:0];
                    cvdc_pkg::REG_WIDTH:   width_reg = value[10:0];
                    default:               height_reg = value[10:0];
                endcase
            end
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [10:0] pick_size();
        case ($urandom_range(0, 9))
            0:       return 11'($urandom_range(0, 2));
            1:       return 11'($urandom_range(1025, 2047));
            2:       return 11'($urandom_range(13, 40));
            default: return 11'($urandom_range(3, 12));
        endcase
    endfunction

    task automatic compare_result();
        filtered_t got, want;
        got.value = m_axis_tdata[7:0];
        got.row = m_axis_tdata[17:8];
        got.col = m_axis_tdata[27:18];
        got.last = m_axis_tlast;
        if (expected_filtered.size() == 0)
        begin
            if (errors < REPORT_MAX)
                $display("unexpected result: value %0d row %0d col %0d last %0b",
                         got.value, got.row, got.col, got.last);
            errors++;
        end
        else
        begin
            want = expected_filtered.pop_front();
            if (got.value !== want.value || got.row !== want.row || got.col !== want.col ||
                got.last !== want.last)
            begin
                if (errors < REPORT_MAX)
                    $display("mismatch: expected %0d row %0d col %0d last %0b, got %0d %0d %0d %0b",
                             want.value, want.row, want.col, want.last,
                             got.value, got.row, got.col, got.last);
                errors++;
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready) compare_result();
        m_axis_tready <= ($urandom_range(0, 99) >= sink_idle);
    end

    initial
    begin
        frame_row_t row;
        logic [62:0] coef;
        logic [7:0] dvs;
        int start, area, count, v;
        for (int i = 0; i < cvdc_pkg::MAX_WIDTH_DEF; i++)
        begin
            upper_line[i] = '0;
            middle_line[i] = '0;
        end
        for (int i = 0; i < 9; i++) window[i] = '0;
        src_idle = 21;
        sink_idle = 77;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < 20; i++)
        begin
            row = PLAN[i];
            if (row.mask != 0)
            begin
                quiesce();
                write_regs(row.mask, row.coef, row.divisor, row.width, row.height);
            end
            send_frame(row.mode, row.level, row.count, row.fixed);
        end

        start = pixels_sent;
        while (pixels_sent - start < RANDOM_PIXELS)
        begin
            if (pixels_sent - start < RANDOM_PIXELS / 3)
            begin
                src_idle = 21;
                sink_idle = 77;
            end
            else if (pixels_sent - start < 2 * RANDOM_PIXELS / 3)
            begin
                src_idle = 77;
                sink_idle = 21;
            end
            else
            begin
                src_idle = 0;
                sink_idle = 0;
            end
            case ($urandom_range(0, 2))
                0: coef = 63'({$urandom(), $urandom()});
                1:
                begin
                    for (int k = 0; k < 9; k++)
                    begin
                        v = $urandom_range(0, 4) - 2;
                        coef[k*7 +: 7] = v[6:0];
                    end
                end
                default:
                begin
                    for (int k = 0; k < 9; k++) coef[k*7 +: 7] = 7'($urandom_range(0, 1));
                end
            endcase
            case ($urandom_range(0, 3))
                0:       dvs = 8'd0;
                1:       dvs = 8'($urandom_range(1, 255));
                2:       dvs = 8'd255;
                default: dvs = 8'($urandom_range(1, 16));
            endcase
            quiesce();
            write_regs(4'($urandom_range(1, 15)), coef, dvs, pick_size(), pick_size());
            area = eff_cols() * eff_rows();
            if (area <= 600 && $urandom_range(0, 99) < 85)
                count = -1;
            else
                count = $urandom_range(1, 60);
            send_frame(pix_mode_t'($urandom_range(0, 4)), 8'($urandom_range(0, 255)), count, -1);
        end

        quiesce();
        if (errors == 0 && expected_filtered.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/cvdc_pkg.sv
sv/cvdc_ram.sv
sv/cvdc_win_cell.sv
sv/cvdc_div_cell.sv
sv/conv3x3_divide_clamp.sv
tb/tb_top.sv
